[hdl/frequency_ordered_table_unit_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent-assertion shorthands for the frequency ordered table.
// ----------------------------------------------------------------------------
`ifndef FREQUENCY_ORDERED_TABLE_UNIT_ASSERT_SVH
`define FREQUENCY_ORDERED_TABLE_UNIT_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define FOT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("frequency ordered table: assertion failed");

// next-cycle implication, disabled while reset is asserted
`define FOT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("frequency ordered table: assertion failed");

`endif

[hdl/fot_pkg.sv]
// ----------------------------------------------------------------------------
// fot_pkg
// Sizes, command and status codes, and the entry and cell control types.
// ----------------------------------------------------------------------------
package fot_pkg;

	localparam int DEPTH   = 16;
	localparam int VALUE_W = 32;
	localparam int COUNT_W = 16;
	localparam int KEY_W   = 4;
	localparam int CNT_W   = $clog2(DEPTH + 1);

	localparam logic [1:0] CMD_APPEND = 2'd0;
	localparam logic [1:0] CMD_GET    = 2'd1;
	localparam logic [1:0] CMD_SET    = 2'd2;

	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_MISS = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [VALUE_W-1:0] value;
		logic [COUNT_W-1:0] hits;
	} entry_t;

	// update command for one cell
	typedef struct packed {
		logic load_left;
		logic load_bcast;
	} cell_ctl_t;

endpackage

[hdl/fot_cell.sv]
// ----------------------------------------------------------------------------
// fot_cell
// One table slot: holds an entry, compares its key and count, and takes the
// broadcast entry or its left neighbor's entry on command.
// ----------------------------------------------------------------------------
module fot_cell
	import fot_pkg::*;
(
	input  logic               clk,
	input  logic               valid,
	input  logic [KEY_W-1:0]   key,
	input  logic [COUNT_W-1:0] ref_count,
	input  entry_t             left,
	input  entry_t             bcast,
	input  cell_ctl_t          ctl,
	output entry_t             entry,
	output logic               match,
	output logic               lt
);

	entry_t entry_q;

	always_ff @(posedge clk) begin
		if (ctl.load_bcast) begin
			entry_q <= bcast;
		end else if (ctl.load_left) begin
			entry_q <= left;
		end
	end

	assign entry = entry_q;
	assign match = valid && (entry_q.key == key);
	assign lt    = entry_q.hits < ref_count;

endmodule

[hdl/frequency_ordered_table_unit.sv]
// ----------------------------------------------------------------------------
// frequency_ordered_table_unit
// Self-organizing key/value table ordered by descending access count, built
// as a row of slot cells that shift entries toward the back on promotion.
// ----------------------------------------------------------------------------
//
//  channel | handshake          | fields
//  --------+--------------------+--------------------------------------
//  in      | in_valid, in_stall | cmd, key, value
//  out     | out_valid,out_stall| read_value, assigned_key, status
//
//  A word is accepted in idle, looked up in the next cycle and committed in
//  the cycle after; the commit cycle also accepts the next word, so a new
//  word can enter while the last commits. The pace is set by the two
//  passes over the cell row: key match, then count compare and shift.
//  A stalled output holds the commit cycle (and with it the input side).
//  arst_n clears the control state and the fill count; slot contents need
//  no clearing since only filled slots are ever matched.
//
module frequency_ordered_table_unit
	import fot_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         cmd,
	input  logic [KEY_W-1:0]   key,
	input  logic [VALUE_W-1:0] value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [VALUE_W-1:0] read_value,
	output logic [KEY_W-1:0]   assigned_key,
	output logic [1:0]         status
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_LOOK = 2'd1;
	localparam logic [1:0] S_UPD  = 2'd2;

	logic [1:0]         state_q;
	logic [CNT_W-1:0]   fill_q;

	// request held from accept
	logic [1:0]         cmd_q;
	logic [KEY_W-1:0]   key_q;
	logic [VALUE_W-1:0] value_q;

	// lookup results
	logic [DEPTH-1:0]   hit_oh_q;
	logic               do_hit_q;
	logic               app_ok_q;
	entry_t             upd_entry_q;
	logic [VALUE_W-1:0] res_value_q;
	logic [KEY_W-1:0]   res_key_q;
	logic [1:0]         res_status_q;

	// output register
	logic               out_valid_q;
	logic [VALUE_W-1:0] read_value_q;
	logic [KEY_W-1:0]   assigned_key_q;
	logic [1:0]         status_q;

	// cell row
	entry_t             cell_entry [DEPTH];
	cell_ctl_t          cell_ctl   [DEPTH];
	logic [DEPTH-1:0]   match_vec;
	logic [DEPTH-1:0]   lt_vec;
	logic [DEPTH-1:0]   valid_vec;
	logic [DEPTH:0]     therm;
	entry_t             bcast;

	logic               accept;
	logic               fire_upd;

	// lookup-stage logic
	logic [DEPTH-1:0]   first_oh;
	entry_t             hit_entry;
	logic               hit_any;
	logic               is_lookup;
	logic               app_ok;
	logic [COUNT_W-1:0] new_hits;

	// update-stage logic
	logic [DEPTH-1:0]   at_or_before;
	logic [DEPTH-1:0]   move_vec;
	logic [DEPTH-1:0]   move_start;
	logic [DEPTH-1:0]   app_oh;

	assign fire_upd = (state_q == S_UPD) && (!out_valid_q || !out_stall);
	assign in_stall = !((state_q == S_IDLE) || fire_upd);
	assign accept   = in_valid && !in_stall;

	// cell i is filled when i < fill count
	assign therm     = ({{DEPTH{1'b0}}, 1'b1} << fill_q) - {{DEPTH{1'b0}}, 1'b1};
	assign valid_vec = therm[DEPTH-1:0];

	// ---- lookup: first match in table order, hit entry, result ----
	assign first_oh  = match_vec & (~match_vec + {{(DEPTH-1){1'b0}}, 1'b1});
	assign hit_any   = |match_vec;
	assign is_lookup = (cmd_q == CMD_GET) || (cmd_q == CMD_SET);
	assign app_ok    = (cmd_q == CMD_APPEND) && (fill_q < CNT_W'(DEPTH));

	always_comb begin
		hit_entry = '0;
		for (int j = 0; j < DEPTH; j++) begin
			if (first_oh[j]) begin
				hit_entry = hit_entry | cell_entry[j];
			end
		end
	end

	// saturate the count at its top
	assign new_hits = (hit_entry.hits == {COUNT_W{1'b1}}) ? hit_entry.hits
		: hit_entry.hits + {{(COUNT_W-1){1'b0}}, 1'b1};

	// ---- update: shift the block of smaller counts back by one slot ----
	assign at_or_before = hit_oh_q | (hit_oh_q - {{(DEPTH-1){1'b0}}, 1'b1});
	assign move_vec     = do_hit_q ? (lt_vec & at_or_before) : '0;
	assign move_start   = move_vec & ~(move_vec << 1);
	assign app_oh       = app_ok_q ? therm[DEPTH-1:0] ^ (therm[DEPTH-1:0] << 1) ^
		{{(DEPTH-1){1'b0}}, 1'b1} : '0;
	// app_oh: lowest unfilled slot (therm ones below it, zero above)

	always_comb begin
		if (app_ok_q) begin
			bcast.key   = KEY_W'(fill_q);
			bcast.value = value_q;
			bcast.hits  = '0;
		end else begin
			bcast = upd_entry_q;
		end
	end

	always_comb begin
		for (int j = 0; j < DEPTH; j++) begin
			cell_ctl[j].load_bcast = fire_upd && (app_oh[j] || move_start[j] ||
				(do_hit_q && hit_oh_q[j] && !move_vec[j]));
			cell_ctl[j].load_left  = fire_upd && move_vec[j] && !move_start[j];
		end
	end

	// ---- cell row ----
	for (genvar j = 0; j < DEPTH; j++) begin : g_cell
		entry_t left_entry;
		if (j == 0) begin : g_head
			assign left_entry = '0;
		end else begin : g_body
			assign left_entry = cell_entry[j-1];
		end
		fot_cell u_cell (
			.clk       (clk),
			.valid     (valid_vec[j]),
			.key       (key_q),
			.ref_count (upd_entry_q.hits),
			.left      (left_entry),
			.bcast     (bcast),
			.ctl       (cell_ctl[j]),
			.entry     (cell_entry[j]),
			.match     (match_vec[j]),
			.lt        (lt_vec[j])
		);
	end

	// ---- sequencer and fill count ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_LOOK;
					end
				end
				S_LOOK: begin
					state_q <= S_UPD;
				end
				S_UPD: begin
					if (fire_upd) begin
						state_q <= accept ? S_LOOK : S_IDLE;
						if (app_ok_q) begin
							fill_q <= fill_q + {{(CNT_W-1){1'b0}}, 1'b1};
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// hold the request word
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= cmd;
			key_q   <= key;
			value_q <= value;
		end
	end

	// register lookup results and the word's result
	always_ff @(posedge clk) begin
		if (state_q == S_LOOK) begin
			hit_oh_q          <= first_oh;
			do_hit_q          <= is_lookup && hit_any;
			app_ok_q          <= app_ok;
			upd_entry_q.key   <= hit_entry.key;
			upd_entry_q.value <= (cmd_q == CMD_SET) ? value_q : hit_entry.value;
			upd_entry_q.hits  <= new_hits;
			res_key_q         <= app_ok ? KEY_W'(fill_q) : key_q;
			if (is_lookup && hit_any) begin
				res_value_q  <= (cmd_q == CMD_SET) ? value_q : hit_entry.value;
				res_status_q <= ST_DONE;
			end else if (is_lookup) begin
				res_value_q  <= valid_vec[0] ? cell_entry[0].value : '0;
				res_status_q <= ST_MISS;
			end else if (cmd_q == CMD_APPEND && !app_ok) begin
				res_value_q  <= '0;
				res_status_q <= ST_FULL;
			end else begin
				res_value_q  <= '0;
				res_status_q <= ST_DONE;
			end
		end
	end

	// output register: load on commit, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_upd) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_upd) begin
			read_value_q   <= res_value_q;
			assigned_key_q <= res_key_q;
			status_q       <= res_status_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign read_value   = read_value_q;
	assign assigned_key = assigned_key_q;
	assign status       = status_q;

endmodule

[hdl/fot_checker.sv]
// ----------------------------------------------------------------------------
// fot_checker
// Port-level checks of the frequency ordered table, bound to the top level.
// ----------------------------------------------------------------------------
`include "frequency_ordered_table_unit_assert.svh"

module fot_checker
	import fot_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic [VALUE_W-1:0] read_value,
	input logic [KEY_W-1:0]   assigned_key,
	input logic [1:0]         status
);

	logic in_acc;
	assign in_acc = in_valid && !in_stall;

	// a stalled result word holds
	`FOT_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(read_value) && $stable(assigned_key) && $stable(status))

	// one word at a time: input closes right after an accept
	`FOT_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_acc, in_stall)

	// a fresh result follows a lookup cycle, and a lookup cycle takes no word
	`FOT_ASSERT_NOW(a_no_early_result, clk, arst_n, $rose(out_valid), !$past(in_acc, 2))

	// status stays within its codes
	`FOT_ASSERT_NOW(a_status_code, clk, arst_n, out_valid, status == ST_DONE || status == ST_MISS || status == ST_FULL)

endmodule

bind frequency_ordered_table_unit fot_checker u_fot_checker (.*);

[tb/tb_frequency_ordered_table_unit.sv]
// ----------------------------------------------------------------------------
// tb_frequency_ordered_table_unit
// Self-checking bench for the frequency ordered table. A shadow copy of the
// table predicts the reply to every accepted word; replies are compared in
// order. Both channels idle and stall at random around directed checks, a
// slow-fill random run with misses, a hot-key burst, and a full-table run.
// ----------------------------------------------------------------------------
module tb_frequency_ordered_table_unit;
	import fot_pkg::*;

	// the one command code the package leaves unnamed; the unit ignores it
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	localparam int IDLE_MAX    = 18;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int SETTLE      = 16;
	localparam int BURST_WORDS = 100;

	typedef struct packed {
		logic [VALUE_W-1:0] read_value;
		logic [KEY_W-1:0]   assigned_key;
		logic [1:0]         status;
	} reply_t;

	// ------------------------------------------------------------------------
	// Shadow table: mirrors slot order, counts and fill level, and queues the
	// reply that each accepted word must produce.
	// ------------------------------------------------------------------------
	class hit_table_shadow;
		entry_t      slots[DEPTH];
		int          filled;
		reply_t      due_replies[$];
		int unsigned faults;
		int unsigned n_hits, n_misses, n_full, n_unused, n_pinned, n_moves;

		function new();
			filled = 0;
			faults = 0;
			n_hits = 0; n_misses = 0; n_full = 0;
			n_unused = 0; n_pinned = 0; n_moves = 0;
		endfunction

		function void apply_request(logic [1:0] c, logic [KEY_W-1:0] k,
				logic [VALUE_W-1:0] v);
			reply_t r;
			entry_t t;
			int     pos;
			int     i;
			bit     found;
			r.read_value   = '0;
			r.assigned_key = k;
			r.status       = ST_DONE;
			case (c)
				CMD_APPEND: begin
					if (filled >= DEPTH) begin
						r.status = ST_FULL;
						n_full++;
					end else begin
						slots[filled].key   = KEY_W'(filled);
						slots[filled].value = v;
						slots[filled].hits  = '0;
						r.assigned_key      = KEY_W'(filled);
						filled++;
					end
				end
				CMD_GET, CMD_SET: begin
					found = 1'b0;
					pos   = 0;
					for (i = 0; i < filled && !found; i++) begin
						if (slots[i].key == k) begin
							found = 1'b1;
							pos   = i;
						end
					end
					if (found) begin
						n_hits++;
						if (slots[pos].hits != '1)
							slots[pos].hits = slots[pos].hits + 1'b1;
						else
							n_pinned++;
						if (c == CMD_SET)
							slots[pos].value = v;
						// advance past strictly smaller counts only
						while (pos > 0 && slots[pos-1].hits < slots[pos].hits) begin
							t            = slots[pos-1];
							slots[pos-1] = slots[pos];
							slots[pos]   = t;
							pos--;
							n_moves++;
						end
						r.read_value = slots[pos].value;
					end else begin
						n_misses++;
						r.status     = ST_MISS;
						r.read_value = (filled > 0) ? slots[0].value : '0;
					end
				end
				default: n_unused++;
			endcase
			due_replies = {due_replies, r};
		endfunction

		function void note_fault(string msg);
			faults++;
			if (faults <= 10)
				$display("mismatch %0d: %s", faults, msg);
		endfunction

		function void compare_reply(logic [VALUE_W-1:0] rv, logic [KEY_W-1:0] ak,
				logic [1:0] st);
			reply_t want;
			if (due_replies.size() == 0) begin
				note_fault($sformatf("reply with none pending: value=%h key=%0d status=%0d",
					rv, ak, st));
				return;
			end
			want = due_replies.pop_front();
			if (want.read_value !== rv || want.assigned_key !== ak || want.status !== st)
				note_fault($sformatf({"expected value=%h key=%0d status=%0d, ",
					"got value=%h key=%0d status=%0d"},
					want.read_value, want.assigned_key, want.status, rv, ak, st));
		endfunction

		function int outstanding();
			return due_replies.size();
		endfunction
	endclass

	logic               clk;
	logic               arst_n    = 1'b0;
	logic               in_valid  = 1'b0;
	logic               in_stall;
	logic [1:0]         cmd       = CMD_APPEND;
	logic [KEY_W-1:0]   key       = '0;
	logic [VALUE_W-1:0] value     = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [VALUE_W-1:0] read_value;
	logic [KEY_W-1:0]   assigned_key;
	logic [1:0]         status;

	hit_table_shadow shadow = new();

	// idling controls for the feed and the sink
	bit feed_idle     = 1'b1;
	bit sink_idle     = 1'b1;
	bit sink_quiet    = 1'b0;
	int sink_holdoff  = 0;
	int appends_sent  = 0;
	int cycle_count   = 0;

	frequency_ordered_table_unit uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cmd          (cmd),
		.key          (key),
		.value        (value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.read_value   (read_value),
		.assigned_key (assigned_key),
		.status       (status)
	);

	always begin
		clk = 1'b0; #5;
		clk = 1'b1; #5;
	end

	// Guard against a hung handshake: stop hard once the cycle budget is gone.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Sample both channels on the rising edge. The reply taken at an edge
	// always belongs to an older word, so the order of the two calls is free.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				shadow.compare_reply(read_value, assigned_key, status);
			if (in_valid && !in_stall)
				shadow.apply_request(cmd, key, value);
		end
	end

	// Reply sink: before each reply, hold stall for a drawn number of cycles
	// (or for a requested hold-off), then drop it until a word is taken.
	initial begin : reply_sink
		int hold;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (sink_holdoff > 0) begin
				hold         = sink_holdoff;
				sink_holdoff = 0;
			end else begin
				hold = (sink_idle && !sink_quiet) ? $urandom_range(0, IDLE_MAX) : 0;
			end
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			@(negedge clk);
			// flip idling now and then so runs with no gaps occur too
			if ($urandom_range(0, 63) == 0)
				sink_idle = !sink_idle;
		end
	end

	function automatic logic [VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			2:       return VALUE_W'(1) << $urandom_range(0, VALUE_W - 1);
			default: return $urandom;
		endcase
	endfunction

	// Offer one word and hold it until taken. Called and returns at a falling
	// edge; valid stays high on return so a back-to-back word needs no gap.
	task automatic send_word(input logic [1:0] c, input logic [KEY_W-1:0] k,
			input logic [VALUE_W-1:0] v);
		int gap;
		gap = feed_idle ? $urandom_range(0, IDLE_MAX) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		cmd      <= c;
		key      <= k;
		value    <= v;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (c == CMD_APPEND)
			appends_sent++;
		@(negedge clk);
	endtask

	// Drop valid and wait until every predicted reply has been taken.
	task automatic drain_replies();
		in_valid <= 1'b0;
		while (shadow.outstanding() > 0) @(negedge clk);
	endtask

	// Random mix of get, set and unused commands, with appends rationed by
	// a per-mille rate and a cap on the fill level. A third of the keys come
	// from a small hot set so that counts spread out and entries keep moving.
	task automatic random_words(input int count, input int append_pm,
			input int append_cap);
		int          roll;
		logic [1:0]  c;
		logic [KEY_W-1:0] k;
		repeat (count) begin
			roll = $urandom_range(0, 999);
			if (roll < append_pm && appends_sent < append_cap)
				c = CMD_APPEND;
			else if (roll >= 980)
				c = CMD_UNUSED;
			else if (roll % 2 == 1)
				c = CMD_GET;
			else
				c = CMD_SET;
			if ($urandom_range(0, 2) == 0)
				k = KEY_W'($urandom_range(0, 3));
			else
				k = KEY_W'($urandom_range(0, 15));
			send_word(c, k, pick_value());
			if ($urandom_range(0, 63) == 0)
				feed_idle = !feed_idle;
		end
	endtask

	initial begin : stimulus
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: fill three slots with extreme values, then lookups that
		// hit, miss, tie and promote. Never look up before the first append,
		// since slot contents are unknown until written.
		send_word(CMD_APPEND, 4'd15, '0);
		send_word(CMD_APPEND, 4'd0,  '1);
		send_word(CMD_APPEND, 4'd7,  32'hA5A5_5A5A);
		send_word(CMD_GET,    4'd15, '1);                // miss: first entry back
		send_word(CMD_SET,    4'd14, '1);                // miss on set leaves value
		send_word(CMD_GET,    4'd2,  '0);                // hit, advance to front
		send_word(CMD_GET,    4'd1,  '0);                // ties with front, stays 2nd
		send_word(CMD_GET,    4'd9,  '0);
		send_word(CMD_SET,    4'd0,  32'h0000_0001);     // equal counts keep order
		send_word(CMD_SET,    4'd0,  '1);                // now strictly ahead
		send_word(CMD_GET,    4'd13, 32'h5555_AAAA);
		send_word(CMD_UNUSED, 4'd15, '1);
		send_word(CMD_UNUSED, 4'd0,  '0);
		send_word(CMD_APPEND, 4'd3,  32'h8000_0001);
		repeat (4) send_word(CMD_GET, 4'd3, '0);
		send_word(CMD_SET,    4'd1,  32'hFFFF_0000);
		send_word(CMD_GET,    4'd12, '0);
		drain_replies();

		// Random with a slow fill, so misses keep exposing the front entry.
		random_words(400, 8, 13);

		// Hold the sink off for a long stretch while words keep coming, so
		// the unit backs up and stalls its input.
		sink_holdoff = 300;
		random_words(100, 8, 13);

		// Pause the feed until every reply is in, then go on.
		drain_replies();
		random_words(550, 8, 13);

		// Hot key: hammer one key with no idling on either side so its count
		// runs well ahead of the rest, then look around with misses.
		feed_idle  = 1'b0;
		sink_quiet = 1'b1;
		repeat (BURST_WORDS)
			send_word(($urandom_range(0, 1) == 0) ? CMD_GET : CMD_SET, 4'd1, pick_value());
		sink_quiet = 1'b0;
		feed_idle  = 1'b1;
		random_words(120, 0, 13);

		// Fill the table, append past the end, then run on the full table.
		while (appends_sent < DEPTH)
			send_word(CMD_APPEND, KEY_W'($urandom_range(0, 15)), pick_value());
		send_word(CMD_APPEND, 4'd15, '1);
		send_word(CMD_APPEND, 4'd0,  '0);
		random_words(230, 100, DEPTH + 1000);

		drain_replies();
		repeat (SETTLE) @(negedge clk);
		if (shadow.outstanding() != 0)
			shadow.note_fault($sformatf("%0d replies never arrived", shadow.outstanding()));

		$display("covered %0d hits (%0d at a pinned count), %0d misses, %0d moves",
			shadow.n_hits, shadow.n_pinned, shadow.n_misses, shadow.n_moves);
		$display("covered %0d appends to a full table, %0d unused commands, %0d faults",
			shadow.n_full, shadow.n_unused, shadow.faults);
		if (shadow.faults == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

[sim.f]
+incdir+hdl
hdl/fot_pkg.sv
hdl/fot_cell.sv
hdl/frequency_ordered_table_unit.sv
hdl/fot_checker.sv
tb/tb_frequency_ordered_table_unit.sv
